FILE: design/mlm_pkg.sv
`default_nettype none

package mlm_pkg;

  localparam int KIND_W   = 2;
  localparam int TID_W    = 8;
  localparam int COND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int NCOND_W  = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENTER  = 2'd0,
    KIND_LEAVE  = 2'd1,
    KIND_WAIT   = 2'd2,
    KIND_SIGNAL = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_COND = 2'd2
  } status_t;

  typedef struct packed {
    logic [TID_W-1:0] wake_thread;
    status_t          status;
    logic             last;
  } rsp_t;

endpackage

`default_nettype wire

FILE: design/mlm_if.sv
`default_nettype none

interface mlm_req_if;
  import mlm_pkg::*;
  logic                valid;
  logic                ready;
  kind_t               kind;
  logic [TID_W-1:0]    thread_id;
  logic [COND_W-1:0]   cond_index;
  modport source (output valid, kind, thread_id, cond_index, input ready);
  modport sink (input valid, kind, thread_id, cond_index, output ready);
endinterface

interface mlm_rsp_if;
  import mlm_pkg::*;
  logic                valid;
  logic                ready;
  logic [TID_W-1:0]    wake_thread;
  status_t             status;
  logic                last;
  modport source (output valid, wake_thread, status, last, input ready);
  modport sink (input valid, wake_thread, status, last, output ready);
endinterface

interface mlm_cfg_if;
  import mlm_pkg::*;
  logic                valid;
  logic                ready;
  logic [NCOND_W-1:0]  num_conds;
  modport source (output valid, num_conds, input ready);
  modport sink (input valid, num_conds, output ready);
endinterface

`default_nettype wire

FILE: design/mlm_ram.sv
`default_nettype none

module mlm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/monitor_lock_manager.sv
`default_nettype none

// Hoare monitor manager (signal and urgent wait). Each request transfer is enter, leave,
// wait or signal; each response transfer names a thread to release, with a status and a
// last flag marking the final response of its request. A request is handled by a read of
// the heads of the entrance, urgent and condition queue memories (registered read port),
// then a commit that updates pointers and loads up to two responses into a two-entry
// output buffer. A new request is taken during the commit cycle; the next starts once the
// buffer drains, and a request with two responses needs the second drained first. The
// user must write num_conds only while idle; the block itself does not enforce this.
module monitor_lock_manager #(
  parameter int MAX_WAITERS     = 16,
  parameter int NUM_CV          = 8,
  parameter int THREAD_ID_WIDTH = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  mlm_req_if.sink   req,
  mlm_rsp_if.source rsp,
  mlm_cfg_if.sink   cfg
);

  import mlm_pkg::*;

  localparam int MW     = MAX_WAITERS;
  localparam int TW     = (THREAD_ID_WIDTH > TID_W) ? TID_W : THREAD_ID_WIDTH;
  localparam int NCV    = (NUM_CV > (1 << COND_W)) ? (1 << COND_W) : NUM_CV;
  localparam int PW     = $clog2(MW);
  localparam int CW     = $clog2(MW + 1);
  localparam int CIW    = (NCV > 1) ? $clog2(NCV) : 1;
  localparam int CDEPTH = NCV * MW;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'b01,
    PH_COMMIT = 2'b10
  } phase_t;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(MW - 1)) ? '0 : p + 1'b1;
  endfunction

  phase_t              phase;
  logic                in_full;
  kind_t               kind_r;
  logic [TW-1:0]       tid_r;
  logic [COND_W-1:0]   ci_r;
  logic [NCOND_W-1:0]  num_conds;
  logic                busy;

  logic [PW-1:0]       ehead, etail, uhead, utail;
  logic [CW-1:0]       ecount, ucount;
  logic [PW-1:0]       chead  [NCV];
  logic [PW-1:0]       ctail  [NCV];
  logic [CW-1:0]       ccount [NCV];

  rsp_t                oslot0, oslot1;
  logic [1:0]          ocnt;

  logic                accept, pop, start, commit;
  logic                cond_ok;
  logic [CIW-1:0]      ci_sel;
  logic [TW-1:0]       e_q, u_q, c_q;
  logic [CAW-1:0]      c_raddr, c_waddr;

  logic                busy_next;
  logic                e_push, e_pop, u_push, u_pop, c_push, c_pop;
  rsp_t                r0, r1;
  logic [1:0]          n;
  logic                have_u, have_e;
  logic [TW-1:0]       woken;

  assign accept    = req.valid && req.ready;
  assign pop       = rsp.valid && rsp.ready;
  assign commit    = (phase == PH_COMMIT);
  assign start     = in_full && (phase == PH_IDLE) && ((ocnt == 2'd0) || ((ocnt == 2'd1) && pop));
  assign req.ready = !in_full || commit;
  assign cfg.ready = 1'b1;

  assign cond_ok = ({1'b0, ci_r} < num_conds) && ({1'b0, ci_r} < NCOND_W'(NCV));
  assign ci_sel  = cond_ok ? ci_r[CIW-1:0] : '0;
  assign c_raddr = CAW'(ci_sel) * CAW'(MW) + CAW'(chead[ci_sel]);
  assign c_waddr = CAW'(ci_sel) * CAW'(MW) + CAW'(ctail[ci_sel]);

  mlm_ram #(.DEPTH(MW), .WIDTH(TW)) u_entrance (
    .clk   (clk),
    .we    (commit && e_push),
    .waddr (etail),
    .wdata (tid_r),
    .raddr (ehead),
    .rdata (e_q)
  );

  mlm_ram #(.DEPTH(MW), .WIDTH(TW)) u_urgent (
    .clk   (clk),
    .we    (commit && u_push),
    .waddr (utail),
    .wdata (tid_r),
    .raddr (uhead),
    .rdata (u_q)
  );

  mlm_ram #(.DEPTH(CDEPTH), .WIDTH(TW)) u_cond (
    .clk   (clk),
    .we    (commit && c_push),
    .waddr (c_waddr),
    .wdata (tid_r),
    .raddr (c_raddr),
    .rdata (c_q)
  );

  assign have_u = (ucount != '0);
  assign have_e = (ecount != '0);
  assign woken  = have_u ? u_q : e_q;

  always_comb begin
    busy_next = busy;
    e_push    = 1'b0;
    e_pop     = 1'b0;
    u_push    = 1'b0;
    u_pop     = 1'b0;
    c_push    = 1'b0;
    c_pop     = 1'b0;
    r0        = '{wake_thread: TID_W'(tid_r), status: ST_OK, last: 1'b1};
    r1        = '{wake_thread: TID_W'(tid_r), status: ST_OK, last: 1'b1};
    n         = 2'd0;
    unique case (kind_r)
      KIND_ENTER: begin
        n = 2'd1;
        if (!busy) begin
          busy_next = 1'b1;
        end else if (ecount == CW'(MW)) begin
          r0.status = ST_FULL;
        end else begin
          e_push = 1'b1;
          n      = 2'd0;
        end
      end
      KIND_LEAVE: begin
        if (have_u || have_e) begin
          u_pop          = have_u;
          e_pop          = !have_u;
          r0.wake_thread = TID_W'(woken);
          r0.last        = 1'b0;
          n              = 2'd2;
        end else begin
          busy_next = 1'b0;
          n         = 2'd1;
        end
      end
      KIND_WAIT: begin
        if (!cond_ok) begin
          r0.status = ST_BAD_COND;
          n         = 2'd1;
        end else if (ccount[ci_sel] == CW'(MW)) begin
          r0.status = ST_FULL;
          n         = 2'd1;
        end else begin
          c_push = 1'b1;
          if (have_u || have_e) begin
            u_pop          = have_u;
            e_pop          = !have_u;
            r0.wake_thread = TID_W'(woken);
            n              = 2'd1;
          end else begin
            busy_next = 1'b0;
          end
        end
      end
      KIND_SIGNAL: begin
        n = 2'd1;
        if (!cond_ok) begin
          r0.status = ST_BAD_COND;
        end else if (ccount[ci_sel] != '0) begin
          if (ucount == CW'(MW)) begin
            r0.status = ST_FULL;
          end else begin
            c_pop          = 1'b1;
            u_push         = 1'b1;
            r0.wake_thread = TID_W'(c_q);
          end
        end
      end
      default: begin
        n = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= req.kind;
      tid_r  <= req.thread_id[TW-1:0];
      ci_r   <= req.cond_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      in_full   <= 1'b0;
      num_conds <= NCOND_W'(1);
      busy      <= 1'b0;
      ehead     <= '0;
      etail     <= '0;
      ecount    <= '0;
      uhead     <= '0;
      utail     <= '0;
      ucount    <= '0;
      for (int i = 0; i < NCV; i++) begin
        chead[i]  <= '0;
        ctail[i]  <= '0;
        ccount[i] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        num_conds <= cfg.num_conds;
      end
      if (accept) begin
        in_full <= 1'b1;
      end else if (commit) begin
        in_full <= 1'b0;
      end
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_COMMIT;
          end
        end
        PH_COMMIT: begin
          phase <= PH_IDLE;
          busy  <= busy_next;
          if (e_push) begin
            etail  <= wrap_inc(etail);
            ecount <= ecount + 1'b1;
          end
          if (e_pop) begin
            ehead  <= wrap_inc(ehead);
            ecount <= ecount - 1'b1;
          end
          if (u_push) begin
            utail  <= wrap_inc(utail);
            ucount <= ucount + 1'b1;
          end
          if (u_pop) begin
            uhead  <= wrap_inc(uhead);
            ucount <= ucount - 1'b1;
          end
          if (c_push) begin
            ctail[ci_sel]  <= wrap_inc(ctail[ci_sel]);
            ccount[ci_sel] <= ccount[ci_sel] + 1'b1;
          end
          if (c_pop) begin
            chead[ci_sel]  <= wrap_inc(chead[ci_sel]);
            ccount[ci_sel] <= ccount[ci_sel] - 1'b1;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  // two-entry response buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else if (commit) begin
      ocnt <= n;
    end else if (pop) begin
      ocnt <= ocnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      oslot0 <= r0;
      oslot1 <= r1;
    end else if (pop) begin
      oslot0 <= oslot1;
    end
  end

  assign rsp.valid       = (ocnt != 2'd0);
  assign rsp.wake_thread = oslot0.wake_thread;
  assign rsp.status      = oslot0.status;
  assign rsp.last        = oslot0.last;

  a_commit_empty_buf: assert property (@(posedge clk) disable iff (rst)
    commit |-> (ocnt == 2'd0))
    else $error("commit with responses still buffered");

  a_commit_has_item: assert property (@(posedge clk) disable iff (rst)
    commit |-> in_full)
    else $error("commit without a held request");

  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    ocnt != 2'd3)
    else $error("response buffer overflow");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (ecount <= CW'(MW)) && (ucount <= CW'(MW)))
    else $error("queue count beyond depth");

  a_busy_change: assert property (@(posedge clk) disable iff (rst)
    (busy != $past(busy)) |-> $past(commit))
    else $error("busy changed outside commit");

endmodule

`default_nettype wire
